>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The condition must never be true while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/ps2m_pkg.sv
// ----------------------------------------------------------------------------
// ps2m_pkg
// Types, command codes and saturation helpers of the PS/2 mouse device.
// ----------------------------------------------------------------------------
package ps2m_pkg;

    localparam int HISTORY_DEPTH = 6;
    localparam int QUEUE_LIMIT   = 13;
    localparam int MAX_REPLY     = 4;

    // Host command codes.
    localparam logic [7:0] CMD_SCALE_1TO1 = 8'hE6;
    localparam logic [7:0] CMD_SCALE_2TO1 = 8'hE7;
    localparam logic [7:0] CMD_SET_RES    = 8'hE8;
    localparam logic [7:0] CMD_STATUS     = 8'hE9;
    localparam logic [7:0] CMD_READ_ID    = 8'hF2;
    localparam logic [7:0] CMD_SET_RATE   = 8'hF3;
    localparam logic [7:0] CMD_ENABLE     = 8'hF4;
    localparam logic [7:0] CMD_DISABLE    = 8'hF5;
    localparam logic [7:0] CMD_RESET      = 8'hFF;

    // Reply codes.
    localparam logic [7:0] REPLY_ACK    = 8'hFA;
    localparam logic [7:0] REPLY_RESEND = 8'hFE;
    localparam logic [7:0] REPLY_ERROR  = 8'hFC;
    localparam logic [7:0] REPLY_BAT_OK = 8'hAA;
    localparam logic [7:0] ID_WHEEL     = 8'h03;
    localparam logic [7:0] ID_STANDARD  = 8'h00;

    // Configuration register indexes.
    localparam logic CFG_WHEEL_CAPABLE = 1'b0;
    localparam logic CFG_SCAN_ENABLED  = 1'b1;

    // Sample rate knock sequence, entry 0 is the oldest byte.
    localparam logic [HISTORY_DEPTH-1:0][7:0] WHEEL_SEQ =
        {8'h50, 8'hF3, 8'h64, 8'hF3, 8'hC8, 8'hF3};

    // Up to four reply bytes, byte 0 goes out first.
    typedef struct packed {
        logic [MAX_REPLY-1:0][7:0] bytes;
        logic [2:0]                count;
    } t_reply;

    // Device mode seen by the motion path.
    typedef struct packed {
        logic enabled;
        logic wheel_mode;
    } t_mode;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [8:0] clamp9(input logic signed [15:0] v);
        logic signed [8:0] r;
        if (v > 16'sd255) begin
            r = 9'sd255;
        end else if (v < -16'sd256) begin
            r = -9'sd256;
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

    function automatic logic signed [3:0] clamp4(input logic signed [15:0] v);
        logic signed [3:0] r;
        if (v > 16'sd7) begin
            r = 4'sd7;
        end else if (v < -16'sd8) begin
            r = -4'sd8;
        end else begin
            r = v[3:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/ps2_mouse_device.sv
// ----------------------------------------------------------------------------
// ps2_mouse_device
// PS/2 mouse device: host command handling and motion packet generation.
// ----------------------------------------------------------------------------
// The input word is registered in the input register, and its reply bytes in the reply buffer.
// One input word is taken per cycle when each yields at most one byte and the output is not
// stalled; else words wait while the single output byte port sends up to four reply bytes.
// Reset (synchronous, active low) clears all mode flags, parameter registers,
// accumulators, the command history and both configuration registers.
module ps2_mouse_device #(
    parameter int QUEUE_LIMIT = ps2m_pkg::QUEUE_LIMIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic                i_cfg_data,
    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [7:0]          i_cmd_byte,
    input  logic signed [10:0]  i_delta_x,
    input  logic signed [10:0]  i_delta_y,
    input  logic signed [7:0]   i_delta_wheel,
    input  logic [2:0]          i_buttons,
    input  logic [3:0]          i_queue_level,
    // Output channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

`include "assert_macros.svh"

    // Configuration registers.
    logic r_wheel_capable;
    logic r_scan_enabled;

    // Input register: holds one word until the reply buffer can take its result.
    logic               r_in_vld;
    logic               r_operation;
    logic [7:0]         r_cmd_byte;
    logic signed [10:0] r_delta_x;
    logic signed [10:0] r_delta_y;
    logic signed [7:0]  r_delta_wheel;
    logic [2:0]         r_buttons;
    logic [3:0]         r_queue_level;

    // Reply buffer: up to four bytes, shifted out one per accepted output word.
    ps2m_pkg::t_reply   r_buf;

    ps2m_pkg::t_reply   w_cmd_reply;
    ps2m_pkg::t_reply   w_mot_reply;
    ps2m_pkg::t_reply   w_sel_reply;
    ps2m_pkg::t_mode    w_mode;
    logic               w_out_take;
    logic               w_buf_free;
    logic               w_adv;
    logic               w_in_take;

    // The buffer is free for a new result when it is empty or its final byte
    // leaves in this cycle. The input register advances into it then.
    assign w_out_take = o_out_valid && !i_out_stall;
    assign w_buf_free = (r_buf.count == 3'd0) ||
                        ((r_buf.count == 3'd1) && w_out_take);
    assign w_adv      = r_in_vld && w_buf_free;
    assign o_in_stall = r_in_vld && !w_buf_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_capable <= 1'b0;
            r_scan_enabled  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ps2m_pkg::CFG_WHEEL_CAPABLE: r_wheel_capable <= i_cfg_data;
                ps2m_pkg::CFG_SCAN_ENABLED:  r_scan_enabled  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_in_take || (r_in_vld && !w_adv);
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_operation   <= i_operation;
            r_cmd_byte    <= i_cmd_byte;
            r_delta_x     <= i_delta_x;
            r_delta_y     <= i_delta_y;
            r_delta_wheel <= i_delta_wheel;
            r_buttons     <= i_buttons;
            r_queue_level <= i_queue_level;
        end
    end

    // Host bytes go to the command decoder, motion reports to the
    // accumulators. Each unit updates its state only for its own words.
    ps2m_cmd u_cmd (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_adv && !r_operation),
        .i_byte          (r_cmd_byte),
        .i_buttons       (r_buttons),
        .i_wheel_capable (r_wheel_capable),
        .o_reply         (w_cmd_reply),
        .o_mode          (w_mode)
    );

    ps2m_motion #(
        .QUEUE_LIMIT (QUEUE_LIMIT)
    ) u_motion (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_adv && r_operation),
        .i_delta_x       (r_delta_x),
        .i_delta_y       (r_delta_y),
        .i_delta_wheel   (r_delta_wheel),
        .i_buttons       (r_buttons),
        .i_queue_level   (r_queue_level),
        .i_wheel_capable (r_wheel_capable),
        .i_scan_enabled  (r_scan_enabled),
        .i_mode          (w_mode),
        .o_reply         (w_mot_reply)
    );

    assign w_sel_reply = r_operation ? w_mot_reply : w_cmd_reply;

    // A word with no reply bytes loads a zero count and leaves the buffer
    // empty, so the next word follows in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
        end else if (w_adv) begin
            r_buf <= w_sel_reply;
        end else if (w_out_take) begin
            r_buf.count <= r_buf.count - 3'd1;
            for (int i = 0; i < ps2m_pkg::MAX_REPLY - 1; i++) begin
                r_buf.bytes[i] <= r_buf.bytes[i+1];
            end
            r_buf.bytes[ps2m_pkg::MAX_REPLY-1] <= 8'h00;
        end
    end

    assign o_out_valid = (r_buf.count != 3'd0);
    assign o_out_byte  = r_buf.bytes[0];
    assign o_last      = (r_buf.count == 3'd1);

    // The reply buffer never holds more than four bytes.
    `ASSERT_NEVER(a_buf_overflow, i_clk, i_rst_n, r_buf.count > 3'd4,
        "reply buffer count above four")

    // Taking the last byte with no new word behind it empties the output.
    `ASSERT_CLK(a_drain_empty, i_clk, i_rst_n,
        (w_out_take && o_last && !r_in_vld) |=> !o_out_valid,
        "output still valid after final byte drained")

    // A waiting word is not lost: it stays in the input register until it advances.
    `ASSERT_CLK(a_hold_word, i_clk, i_rst_n,
        (r_in_vld && !w_adv) |=> r_in_vld,
        "pending input word dropped")

endmodule

>>> rtl/ps2m_cmd.sv
// ----------------------------------------------------------------------------
// ps2m_cmd
// Host command decoder: mode flags, parameter registers and wheel knock.
// ----------------------------------------------------------------------------
module ps2m_cmd (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic [2:0]           i_buttons,
    input  logic                 i_wheel_capable,
    output ps2m_pkg::t_reply     o_reply,
    output ps2m_pkg::t_mode      o_mode
);

    logic       r_enabled, n_enabled;
    logic       r_scaled, n_scaled;
    logic       r_param_pending, n_param_pending;
    logic       r_wheel_mode, n_wheel_mode;
    logic [7:0] r_pending_cmd, n_pending_cmd;
    logic [7:0] r_resolution, n_resolution;
    logic [7:0] r_rate, n_rate;
    logic [ps2m_pkg::HISTORY_DEPTH-1:0][7:0] r_hist, n_hist;

    always_comb begin
        n_enabled       = r_enabled;
        n_scaled        = r_scaled;
        n_param_pending = r_param_pending;
        n_wheel_mode    = r_wheel_mode;
        n_pending_cmd   = r_pending_cmd;
        n_resolution    = r_resolution;
        n_rate          = r_rate;
        n_hist          = r_hist;
        o_reply         = '0;
        o_reply.bytes[0] = ps2m_pkg::REPLY_ACK;
        o_reply.count    = 3'd1;

        if (r_param_pending) begin
            n_param_pending = 1'b0;
            if (r_pending_cmd == ps2m_pkg::CMD_SET_RES) begin
                n_resolution = i_byte;
            end else if (r_pending_cmd == ps2m_pkg::CMD_SET_RATE) begin
                n_rate = i_byte;
            end else begin
                o_reply.bytes[0] = ps2m_pkg::REPLY_ERROR;
            end
        end else begin
            n_pending_cmd = i_byte;
            unique case (i_byte)
                ps2m_pkg::CMD_SCALE_1TO1: n_scaled = 1'b0;
                ps2m_pkg::CMD_SCALE_2TO1: n_scaled = 1'b1;
                ps2m_pkg::CMD_SET_RES:    n_param_pending = 1'b1;
                ps2m_pkg::CMD_SET_RATE:   n_param_pending = 1'b1;
                ps2m_pkg::CMD_STATUS: begin
                    o_reply.bytes[1] = {2'b00, r_scaled, r_enabled, 1'b0, i_buttons};
                    o_reply.bytes[2] = r_resolution;
                    o_reply.bytes[3] = r_rate;
                    o_reply.count    = 3'd4;
                end
                ps2m_pkg::CMD_READ_ID: begin
                    o_reply.bytes[1] = r_wheel_mode ? ps2m_pkg::ID_WHEEL
                                                    : ps2m_pkg::ID_STANDARD;
                    o_reply.count    = 3'd2;
                end
                ps2m_pkg::CMD_ENABLE:  n_enabled = 1'b1;
                ps2m_pkg::CMD_DISABLE: n_enabled = 1'b0;
                ps2m_pkg::CMD_RESET: begin
                    n_enabled        = 1'b0;
                    n_scaled         = 1'b0;
                    n_wheel_mode     = 1'b0;
                    o_reply.bytes[1] = ps2m_pkg::REPLY_BAT_OK;
                    o_reply.bytes[2] = 8'h00;
                    o_reply.count    = 3'd3;
                end
                default: o_reply.bytes[0] = ps2m_pkg::REPLY_RESEND;
            endcase
        end

        // The history only moves while the device can do wheel mode.
        if (i_wheel_capable) begin
            for (int i = 0; i < ps2m_pkg::HISTORY_DEPTH - 1; i++) begin
                n_hist[i] = r_hist[i+1];
            end
            n_hist[ps2m_pkg::HISTORY_DEPTH-1] = i_byte;
            if (n_hist == ps2m_pkg::WHEEL_SEQ) begin
                n_wheel_mode = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= 1'b0;
            r_scaled        <= 1'b0;
            r_param_pending <= 1'b0;
            r_wheel_mode    <= 1'b0;
            r_pending_cmd   <= '0;
            r_resolution    <= '0;
            r_rate          <= '0;
            r_hist          <= '0;
        end else if (i_fire) begin
            r_enabled       <= n_enabled;
            r_scaled        <= n_scaled;
            r_param_pending <= n_param_pending;
            r_wheel_mode    <= n_wheel_mode;
            r_pending_cmd   <= n_pending_cmd;
            r_resolution    <= n_resolution;
            r_rate          <= n_rate;
            r_hist          <= n_hist;
        end
    end

    assign o_mode.enabled    = r_enabled;
    assign o_mode.wheel_mode = r_wheel_mode;

endmodule

>>> rtl/ps2m_motion.sv
// ----------------------------------------------------------------------------
// ps2m_motion
// Motion accumulators and packet builder.
// ----------------------------------------------------------------------------
module ps2m_motion #(
    parameter int QUEUE_LIMIT = ps2m_pkg::QUEUE_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic signed [10:0]   i_delta_x,
    input  logic signed [10:0]   i_delta_y,
    input  logic signed [7:0]    i_delta_wheel,
    input  logic [2:0]           i_buttons,
    input  logic [3:0]           i_queue_level,
    input  logic                 i_wheel_capable,
    input  logic                 i_scan_enabled,
    input  ps2m_pkg::t_mode      i_mode,
    output ps2m_pkg::t_reply     o_reply
);

    localparam logic [3:0] LIMIT = 4'(QUEUE_LIMIT);

    logic signed [15:0] r_acc_x, r_acc_y, r_acc_w;
    logic [2:0]         r_sent_buttons;

    logic signed [15:0] w_sum_x, w_sum_y, w_sum_w;
    logic signed [8:0]  w_clip_x, w_clip_y;
    logic signed [3:0]  w_clip_w;
    logic               w_idle, w_active, w_send;

    always_comb begin
        w_sum_x = ps2m_pkg::sat16(17'(r_acc_x) + 17'(i_delta_x));
        w_sum_y = ps2m_pkg::sat16(17'(r_acc_y) - 17'(i_delta_y));
        w_sum_w = ps2m_pkg::sat16(17'(r_acc_w) - 17'(i_delta_wheel));
        w_clip_x = ps2m_pkg::clamp9(w_sum_x);
        w_clip_y = ps2m_pkg::clamp9(w_sum_y);
        w_clip_w = ps2m_pkg::clamp4(w_sum_w);

        w_idle   = (i_delta_x == 11'sd0) && (i_delta_y == 11'sd0) &&
                   (i_delta_wheel == 8'sd0) && (i_buttons == r_sent_buttons);
        w_active = !w_idle && i_mode.enabled && i_scan_enabled;
        w_send   = w_active && (i_queue_level < LIMIT);

        o_reply          = '0;
        o_reply.bytes[0] = {2'b00, w_clip_y[8], w_clip_x[8], 1'b1,
                            i_buttons[2] & i_wheel_capable, i_buttons[1:0]};
        o_reply.bytes[1] = w_clip_x[7:0];
        o_reply.bytes[2] = w_clip_y[7:0];
        o_reply.bytes[3] = {{4{w_clip_w[3]}}, w_clip_w};
        if (w_send) begin
            o_reply.count = i_mode.wheel_mode ? 3'd4 : 3'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x        <= '0;
            r_acc_y        <= '0;
            r_acc_w        <= '0;
            r_sent_buttons <= '0;
        end else if (i_fire && w_active) begin
            if (w_send) begin
                r_acc_x        <= '0;
                r_acc_y        <= '0;
                r_acc_w        <= '0;
                r_sent_buttons <= i_buttons;
            end else begin
                r_acc_x <= w_sum_x;
                r_acc_y <= w_sum_y;
                r_acc_w <= w_sum_w;
            end
        end
    end

endmodule
